// ===== hdl/ippb_pkg.sv =====
// Shared types, constants and color helpers for the interlaced palette blender.
package ippb_pkg;

  localparam int unsigned NUM_PLANES  = 4;
  localparam int unsigned PLANE_W     = 16;
  localparam int unsigned NUM_PIXELS  = 16;
  localparam int unsigned PAL_DEPTH   = 32;
  localparam int unsigned PAL_AW      = $clog2(PAL_DEPTH);
  localparam int unsigned PIX_CNT_W   = $clog2(NUM_PIXELS);
  localparam int unsigned COLOR_W     = 12;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // stream widths
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  // request kinds carried in tuser bit 0
  localparam logic REQ_PAL_LOAD = 1'b0;
  localparam logic REQ_GROUP    = 1'b1;

  localparam logic [PIX_CNT_W-1:0] LAST_PIX = PIX_CNT_W'(NUM_PIXELS - 1);

  typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] planes_t;

  // one classified word held in the queue between front and back
  typedef struct packed {
    logic                is_group;
    logic [PAL_AW-1:0]   slot;      // {screen_sel, pal_index}
    logic [COLOR_W-1:0]  color;
    planes_t             a_planes;
    planes_t             b_planes;
  } q_entry_t;

  // back-end progress seen by the top level
  typedef struct packed {
    logic                 mid_group;
    logic [PIX_CNT_W-1:0] pix_cnt;
  } back_status_t;

  // STE nibble to 8 bits: bit 3 is the level LSB, level L gives L * 0x11
  function automatic logic [CHAN_W-1:0] ste_expand(input logic [3:0] nib);
    logic [3:0] lvl;
    lvl = {nib[2:0], nib[3]};
    return {lvl, lvl};
  endfunction

  // floor average of two channel values
  function automatic logic [CHAN_W-1:0] avg2(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CHAN_W:1];
  endfunction

endpackage

// ===== hdl/ippb_front.sv =====
// Front end: unpacks input words, classifies them and queues them for the back end.
module ippb_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ippb_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [ippb_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              q_valid,
  output ippb_pkg::q_entry_t                q_entry,
  input  logic                              q_pop
);

  ippb_pkg::q_entry_t                 q_mem_r [ippb_pkg::Q_DEPTH];
  ippb_pkg::q_entry_t                 entry_in;
  logic [ippb_pkg::Q_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ippb_pkg::Q_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ippb_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                               push;
  logic                               pop;

  // decode the word: tuser = {screen_sel, req_type}
  always_comb begin
    entry_in.is_group      = (in_tuser[0] == ippb_pkg::REQ_GROUP);
    entry_in.slot          = {in_tuser[1], in_tdata[3:0]};
    entry_in.color         = in_tdata[15:4];
    entry_in.a_planes[0]   = in_tdata[31:16];
    entry_in.a_planes[1]   = in_tdata[47:32];
    entry_in.a_planes[2]   = in_tdata[63:48];
    entry_in.a_planes[3]   = in_tdata[79:64];
    entry_in.b_planes[0]   = in_tdata[95:80];
    entry_in.b_planes[1]   = in_tdata[111:96];
    entry_in.b_planes[2]   = in_tdata[127:112];
    entry_in.b_planes[3]   = in_tdata[143:128];
  end

  assign in_tready = (cnt_r != ippb_pkg::Q_CNT_W'(ippb_pkg::Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (cnt_r != '0);
  assign q_entry   = q_mem_r[rd_ptr_r];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ippb_pkg::Q_PTR_W'(ippb_pkg::Q_DEPTH - 1)) ? '0
                                                                      : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ippb_pkg::Q_PTR_W'(ippb_pkg::Q_DEPTH - 1)) ? '0
                                                                      : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry_in;
    end
  end

endmodule

// ===== hdl/ippb_back.sv =====
// Back end: palette memory, pixel sequencer, color expand and blend, output register.
module ippb_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  ippb_pkg::q_entry_t                 q_entry,
  output logic                               q_pop,
  output ippb_pkg::back_status_t             status,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ippb_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast
);

  logic [ippb_pkg::COLOR_W-1:0]   pal_mem [ippb_pkg::PAL_DEPTH];

  logic [ippb_pkg::PIX_CNT_W-1:0] pix_cnt_r, pix_cnt_nxt;
  logic                           adv;
  logic                           pal_wr;
  logic                           issue;
  logic                           pix_last;
  logic [ippb_pkg::PIX_CNT_W-1:0] bit_sel;
  logic [3:0]                     idx_a, idx_b;

  logic                           v1_r;
  logic                           last1_r;
  logic [ippb_pkg::COLOR_W-1:0]   col_a_r, col_b_r;

  logic                           out_valid_r;
  logic                           out_last_r;
  logic [ippb_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [ippb_pkg::OUT_TDATA_W-1:0] blend_px;

  // whole pipe moves when the output register is free or drained
  assign adv      = !out_valid_r || out_tready;
  assign pal_wr   = q_valid && !q_entry.is_group;
  assign issue    = q_valid && q_entry.is_group && adv;
  assign pix_last = (pix_cnt_r == ippb_pkg::LAST_PIX);
  assign q_pop    = pal_wr || (issue && pix_last);

  assign status.mid_group = (pix_cnt_r != '0);
  assign status.pix_cnt   = pix_cnt_r;

  // leftmost pixel is the plane word MSB
  assign bit_sel = ippb_pkg::LAST_PIX - pix_cnt_r;

  always_comb begin
    for (int k = 0; k < ippb_pkg::NUM_PLANES; k++) begin
      idx_a[k] = q_entry.a_planes[k][bit_sel];
      idx_b[k] = q_entry.b_planes[k][bit_sel];
    end
  end

  // pixel counter within a group
  always_comb begin
    pix_cnt_nxt = pix_cnt_r;
    if (issue) begin
      pix_cnt_nxt = pix_last ? '0 : pix_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r <= '0;
    end else begin
      pix_cnt_r <= pix_cnt_nxt;
    end
  end

  // palette memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[q_entry.slot] <= q_entry.color;
    end
    if (adv) begin
      col_a_r <= pal_mem[{1'b0, idx_a}];
      col_b_r <= pal_mem[{1'b1, idx_b}];
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= issue;
      last1_r <= pix_last;
    end
  end

  // expand and average each channel; red in the low byte
  always_comb begin
    blend_px[7:0]   = ippb_pkg::avg2(ippb_pkg::ste_expand(col_a_r[11:8]),
                                     ippb_pkg::ste_expand(col_b_r[11:8]));
    blend_px[15:8]  = ippb_pkg::avg2(ippb_pkg::ste_expand(col_a_r[7:4]),
                                     ippb_pkg::ste_expand(col_b_r[7:4]));
    blend_px[23:16] = ippb_pkg::avg2(ippb_pkg::ste_expand(col_a_r[3:0]),
                                     ippb_pkg::ste_expand(col_b_r[3:0]));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= blend_px;
      out_last_r <= last1_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/interlaced_planar_palette_blender.sv =====
// Top level: two interlaced bitplane screens to blended RGB through line palettes.
// The first pixel of a group is valid after the queue, palette read and output registers.
// A group word gives 16 pixels, one per cycle from the sequencer unless output stalls;
//   palette loads do not wait on the output; a 2-word queue lets input run ahead.
// Reset (rst_n, synchronous, active low) clears queue, sequencer and output valid;
//   palette contents are undefined until loaded.
module interlaced_planar_palette_blender (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] pal_index, [15:4] color_word, [31:16] a_plane0, [47:32] a_plane1,
  // [63:48] a_plane2, [79:64] a_plane3, [95:80] b_plane0, [111:96] b_plane1,
  // [127:112] b_plane2, [143:128] b_plane3
  input  logic [143:0] in_tdata,
  // [0] req_type, [1] screen_sel
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [23:0]  out_tdata,
  // last_pixel
  output logic         out_tlast
);

  logic                    q_valid;
  logic                    q_pop;
  ippb_pkg::q_entry_t      q_entry;
  ippb_pkg::back_status_t  back_st;

  ippb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  ippb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .status     (back_st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a group in progress stays at the queue head
  a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
    back_st.mid_group |-> (q_valid && q_entry.is_group))
    else $error("pixel counter running without a group at the head");

  // an accepted word is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> q_valid)
    else $error("accepted word missing from the queue");

endmodule
